### rtl/core/tpc_pkg.sv
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared types and constants for the temperature and pressure compensation
// block: beat payloads, calibration fields, operation and register codes.
// ----------------------------------------------------------------------------
package tpc_pkg;

    // Raw reading width and the number of significant ADC bits.
    localparam int RAW_W    = 20;
    localparam int ADC_BITS = 20;
    localparam logic [RAW_W-1:0] ADC_KEEP =
        RAW_W'(((64'd1 << ADC_BITS) - 64'd1) << (RAW_W - ADC_BITS));

    // Result and configuration widths.
    localparam int VAL_W     = 32;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_W     = 64;

    // Operation codes carried in op and echoed in kind.
    localparam logic OP_TEMP  = 1'b0;
    localparam logic OP_PRESS = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_CALIB    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_CALIB_A = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_CALIB_B = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_CALIB_C = CFG_IDX_W'(3);

    // Register widths.
    localparam int TEMP_CALIB_W    = 40;
    localparam int PRESS_CALIB_A_W = 56;
    localparam int PRESS_CALIB_B_W = 48;
    localparam int PRESS_CALIB_C_W = 24;

    // Compensation constants.
    localparam longint FINE_OFFSET  = 64000;
    localparam longint PRESS_OFFSET = 1048576;
    localparam longint PRESS_SCALE  = 3125;
    localparam longint UNITY_Q15    = 32768;
    localparam int     P7_SHIFT     = 7;

    // Serial arithmetic units.
    localparam int MUL_W     = 64;
    localparam int MUL_DIGIT = 2;
    localparam int MUL_STEPS = MUL_W / MUL_DIGIT;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS);
    localparam int DIV_W     = 32;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // Input beat.
    typedef struct packed {
        logic             op;
        logic [RAW_W-1:0] raw_reading;
    } tpc_in_t;

    // Result beat.
    typedef struct packed {
        logic                    kind;
        logic signed [VAL_W-1:0] value;
        logic                    div_fault;
    } tpc_out_t;

    // Calibration words unpacked from the configuration registers.
    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [7:0]  t3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [7:0]  p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [7:0]  p6;
        logic [7:0]  p7;
        logic [15:0] p8;
        logic [15:0] p9;
        logic [7:0]  p10;
    } tpc_calib_t;

endpackage

### rtl/core/tpc_serial_mul.sv
// ----------------------------------------------------------------------------
// tpc_serial_mul
// Digit-serial 64 by 64 multiplier, two multiplier bits per cycle, giving the
// product modulo 2^64 (valid for two's complement operands).
// ----------------------------------------------------------------------------
module tpc_serial_mul
    import tpc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [MUL_W-1:0] mcand,
    input  logic [MUL_W-1:0] mplier,
    output logic             busy,
    output logic             done,
    output logic [MUL_W-1:0] prod
);

    logic [MUL_W-1:0]     mcand_reg, mcand_next;
    logic [MUL_W-1:0]     mplier_reg, mplier_next;
    logic [MUL_W-1:0]     acc_reg, acc_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    // One digit of the multiplier is added per cycle.
    always_comb begin
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (start) begin
            mcand_next  = mcand;
            mplier_next = mplier;
            acc_next    = '0;
            cnt_next    = '0;
            busy_next   = 1'b1;
        end else if (busy_reg) begin
            acc_next    = acc_reg
                        + (mplier_reg[0] ? mcand_reg : '0)
                        + (mplier_reg[1] ? {mcand_reg[MUL_W-2:0], 1'b0} : '0);
            mcand_next  = mcand_reg << MUL_DIGIT;
            mplier_next = mplier_reg >> MUL_DIGIT;
            cnt_next    = cnt_reg + 1'b1;
            if (cnt_reg == MUL_CNT_W'(MUL_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign prod = acc_reg;

endmodule

### rtl/core/tpc_serial_div.sv
// ----------------------------------------------------------------------------
// tpc_serial_div
// Restoring unsigned 32-bit divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tpc_serial_div
    import tpc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIV_W-1:0]     dsr_reg, dsr_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_W:0]       rem_sh;

    // Shift in the next dividend bit and subtract the divisor when it fits.
    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg, quo_reg[DIV_W-1]};
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_sh >= {1'b0, dsr_reg}) begin
                rem_next = DIV_W'(rem_sh - {1'b0, dsr_reg});
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/core/tpc_core.sv
// ----------------------------------------------------------------------------
// tpc_core
// Sequencer for the compensation formulas. Each product goes through the
// shared serial multiplier, the pressure quotient through the serial divider;
// additions and shifts are done between steps. Holds the fine temperature.
// ----------------------------------------------------------------------------
module tpc_core
    import tpc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  tpc_calib_t calib,
    input  logic       in_valid,
    output logic       in_ready,
    input  tpc_in_t    in_data,
    output logic       res_valid,
    input  logic       res_ready,
    output tpc_out_t   res_data
);

    // Sequencer states.
    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_T_MUL1 = 5'd1;
    localparam logic [4:0] ST_T_MUL2 = 5'd2;
    localparam logic [4:0] ST_T_MUL3 = 5'd3;
    localparam logic [4:0] ST_T_FIN  = 5'd4;
    localparam logic [4:0] ST_P_M1   = 5'd5;
    localparam logic [4:0] ST_P_M2   = 5'd6;
    localparam logic [4:0] ST_P_M3   = 5'd7;
    localparam logic [4:0] ST_P_M4   = 5'd8;
    localparam logic [4:0] ST_P_M5   = 5'd9;
    localparam logic [4:0] ST_P_M6   = 5'd10;
    localparam logic [4:0] ST_P_M7   = 5'd11;
    localparam logic [4:0] ST_P_CHK  = 5'd12;
    localparam logic [4:0] ST_P_DIV  = 5'd13;
    localparam logic [4:0] ST_P_M8   = 5'd14;
    localparam logic [4:0] ST_P_M9   = 5'd15;
    localparam logic [4:0] ST_P_M10  = 5'd16;
    localparam logic [4:0] ST_P_M11  = 5'd17;
    localparam logic [4:0] ST_P_M12  = 5'd18;
    localparam logic [4:0] ST_P_M13  = 5'd19;
    localparam logic [4:0] ST_P_FIN  = 5'd20;
    localparam logic [4:0] ST_DONE   = 5'd21;

    typedef logic signed [MUL_W-1:0] s64_t;

    function automatic s64_t sx16(input logic [15:0] x);
        return s64_t'($signed(x));
    endfunction

    function automatic s64_t sx8(input logic [7:0] x);
        return s64_t'($signed(x));
    endfunction

    function automatic s64_t zx(input logic [DIV_W-1:0] x);
        return $signed({{(MUL_W-DIV_W){1'b0}}, x});
    endfunction

    logic [4:0]       st_reg, st_next;
    logic             issued_reg, issued_next;
    logic             op_reg, op_next;
    logic [RAW_W-1:0] adc_reg, adc_next;
    s64_t             ra_reg, ra_next;
    s64_t             rb_reg, rb_next;
    s64_t             rt_reg, rt_next;
    s64_t             rsq_reg, rsq_next;
    s64_t             rv_reg, rv_next;
    logic [DIV_W-1:0] rp_reg, rp_next;
    logic [DIV_W-1:0] fine_reg, fine_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic             fault_reg, fault_next;

    logic             mul_start, mul_busy, mul_done, mul_state;
    logic [MUL_W-1:0] mul_prod;
    s64_t             op_a, op_b, prod, tmp;
    logic             div_start, div_busy, div_done;
    logic [DIV_W-1:0] div_dividend, div_quo;
    logic             pr_big;
    logic [RAW_W-1:0] adc_in;

    assign prod   = $signed(mul_prod);
    assign pr_big = (rp_reg[DIV_W-1:DIV_W-2] != 2'b00);
    assign adc_in = in_data.raw_reading & ADC_KEEP;

    // Multiplier operands for each step.
    always_comb begin
        mul_state = 1'b1;
        op_a      = '0;
        op_b      = '0;
        unique case (st_reg)
            ST_T_MUL1: begin op_a = ra_reg;         op_b = sx16(calib.t2); end
            ST_T_MUL2: begin op_a = ra_reg >>> 1;   op_b = ra_reg >>> 1; end
            ST_T_MUL3: begin op_a = rt_reg;         op_b = sx8(calib.t3) <<< 4; end
            ST_P_M1:   begin op_a = ra_reg >>> 2;   op_b = ra_reg >>> 2; end
            ST_P_M2:   begin op_a = rsq_reg >>> 11; op_b = sx8(calib.p6); end
            ST_P_M3:   begin op_a = ra_reg;         op_b = sx16(calib.p5); end
            ST_P_M4:   begin op_a = rsq_reg >>> 13; op_b = sx8(calib.p3) <<< 5; end
            ST_P_M5:   begin op_a = ra_reg;         op_b = sx16(calib.p2); end
            ST_P_M6:   begin op_a = rt_reg + s64_t'(UNITY_Q15);
                             op_b = $signed(MUL_W'(calib.p1)); end
            ST_P_M7:   begin op_a = s64_t'(PRESS_OFFSET) - $signed(MUL_W'(adc_reg))
                                    - (rb_reg >>> 12);
                             op_b = s64_t'(PRESS_SCALE); end
            ST_P_M8:   begin op_a = zx(rp_reg >> 3);  op_b = zx(rp_reg >> 3); end
            ST_P_M9:   begin op_a = rsq_reg;          op_b = sx16(calib.p9); end
            ST_P_M10:  begin op_a = zx(rp_reg >> 2);  op_b = sx16(calib.p8); end
            ST_P_M11:  begin op_a = zx(rp_reg >> 8);  op_b = zx(rp_reg >> 8); end
            ST_P_M12:  begin op_a = rt_reg;           op_b = zx(rp_reg >> 8); end
            ST_P_M13:  begin op_a = rt_reg;  op_b = $signed(MUL_W'(calib.p10)); end
            default:   mul_state = 1'b0;
        endcase
    end

    assign mul_start    = mul_state && !issued_reg;
    assign div_dividend = pr_big ? rp_reg : {rp_reg[DIV_W-2:0], 1'b0};
    assign div_start    = (st_reg == ST_P_CHK) && (rt_reg[DIV_W-1:0] != '0);

    // Step sequencing and the arithmetic done after each product.
    always_comb begin
        st_next     = st_reg;
        issued_next = issued_reg;
        op_next     = op_reg;
        adc_next    = adc_reg;
        ra_next     = ra_reg;
        rb_next     = rb_reg;
        rt_next     = rt_reg;
        rsq_next    = rsq_reg;
        rv_next     = rv_reg;
        rp_next     = rp_reg;
        fine_next   = fine_reg;
        val_next    = val_reg;
        fault_next  = fault_reg;
        tmp         = '0;
        if (mul_start) begin
            issued_next = 1'b1;
        end
        if (mul_state && issued_reg && mul_done) begin
            issued_next = 1'b0;
        end
        unique case (st_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    op_next  = in_data.op;
                    adc_next = adc_in;
                    if (in_data.op == OP_TEMP) begin
                        ra_next = $signed(MUL_W'(adc_in >> 3))
                                - $signed(MUL_W'({calib.t1, 1'b0}));
                        st_next = ST_T_MUL1;
                    end else begin
                        ra_next = (s64_t'($signed(fine_reg)) >>> 1)
                                - s64_t'(FINE_OFFSET);
                        st_next = ST_P_M1;
                    end
                end
            end
            ST_T_FIN: begin
                tmp        = s64_t'($signed(fine_reg));
                tmp        = ((tmp <<< 2) + tmp + s64_t'(128)) >>> 8;
                val_next   = tmp[VAL_W-1:0];
                fault_next = 1'b0;
                st_next    = ST_DONE;
            end
            ST_P_CHK: begin
                if (rt_reg[DIV_W-1:0] == '0) begin
                    val_next   = '0;
                    fault_next = 1'b1;
                    st_next    = ST_DONE;
                end else begin
                    st_next = ST_P_DIV;
                end
            end
            ST_P_DIV: begin
                if (div_done) begin
                    rp_next = pr_big ? {div_quo[DIV_W-2:0], 1'b0} : div_quo;
                    st_next = ST_P_M8;
                end
            end
            ST_P_FIN: begin
                tmp        = zx(rp_reg)
                           + ((rv_reg + (sx8(calib.p7) <<< P7_SHIFT)) >>> 4);
                val_next   = tmp[VAL_W-1:0];
                fault_next = 1'b0;
                st_next    = ST_DONE;
            end
            ST_DONE: begin
                if (res_ready) begin
                    st_next = ST_IDLE;
                end
            end
            default: begin
                if (issued_reg && mul_done) begin
                    case (st_reg)
                        ST_T_MUL1: begin rb_next = prod >>> 11; st_next = ST_T_MUL2; end
                        ST_T_MUL2: begin rt_next = prod >>> 12; st_next = ST_T_MUL3; end
                        ST_T_MUL3: begin
                            tmp       = rb_reg + (prod >>> 14);
                            fine_next = tmp[DIV_W-1:0];
                            st_next   = ST_T_FIN;
                        end
                        ST_P_M1: begin rsq_next = prod; st_next = ST_P_M2; end
                        ST_P_M2: begin rb_next = prod >>> 2; st_next = ST_P_M3; end
                        ST_P_M3: begin
                            rb_next = ((rb_reg + (prod <<< 1)) >>> 2)
                                    + (sx16(calib.p4) <<< 16);
                            st_next = ST_P_M4;
                        end
                        ST_P_M4: begin rt_next = prod >>> 3; st_next = ST_P_M5; end
                        ST_P_M5: begin
                            rt_next = (rt_reg + (prod >>> 1)) >>> 18;
                            st_next = ST_P_M6;
                        end
                        ST_P_M6: begin rt_next = prod >>> 15; st_next = ST_P_M7; end
                        ST_P_M7: begin rp_next = mul_prod[DIV_W-1:0]; st_next = ST_P_CHK; end
                        ST_P_M8: begin rsq_next = prod >>> 13; st_next = ST_P_M9; end
                        ST_P_M9: begin rv_next = prod >>> 12; st_next = ST_P_M10; end
                        ST_P_M10: begin
                            rv_next = rv_reg + (prod >>> 13);
                            st_next = ST_P_M11;
                        end
                        ST_P_M11: begin rt_next = prod; st_next = ST_P_M12; end
                        ST_P_M12: begin rt_next = prod; st_next = ST_P_M13; end
                        ST_P_M13: begin
                            rv_next = rv_reg + $signed(mul_prod >> 17);
                            st_next = ST_P_FIN;
                        end
                        default: st_next = ST_IDLE;
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg     <= ST_IDLE;
            issued_reg <= 1'b0;
            fine_reg   <= '0;
        end else begin
            st_reg     <= st_next;
            issued_reg <= issued_next;
            fine_reg   <= fine_next;
        end
        op_reg    <= op_next;
        adc_reg   <= adc_next;
        ra_reg    <= ra_next;
        rb_reg    <= rb_next;
        rt_reg    <= rt_next;
        rsq_reg   <= rsq_next;
        rv_reg    <= rv_next;
        rp_reg    <= rp_next;
        val_reg   <= val_next;
        fault_reg <= fault_next;
    end

    // Shared arithmetic units.
    tpc_serial_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mcand   (MUL_W'(op_a)),
        .mplier  (MUL_W'(op_b)),
        .busy    (mul_busy),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    tpc_serial_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (rt_reg[DIV_W-1:0]),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign in_ready           = (st_reg == ST_IDLE);
    assign res_valid          = (st_reg == ST_DONE);
    assign res_data.kind      = op_reg;
    assign res_data.value     = $signed(val_reg);
    assign res_data.div_fault = fault_reg;

    // A new product is never started over one in progress.
    assert property (@(posedge aclk) disable iff (!aresetn)
        mul_start |-> !mul_busy)
        else $error("multiplier started while busy");

    // The divider only ever sees a nonzero divisor and an idle unit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> (!div_busy && rt_reg[DIV_W-1:0] != '0))
        else $error("divider started with zero divisor or while busy");

    // A faulted pressure result carries a zero value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && fault_reg) |-> (val_reg == '0 && op_reg == OP_PRESS))
        else $error("fault result with nonzero value or wrong kind");

    // The fine temperature changes only at the end of a temperature item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fine_reg != $past(fine_reg)) |-> (st_reg == ST_T_FIN && op_reg == OP_TEMP))
        else $error("fine temperature changed outside a temperature item");

endmodule

### rtl/core/temp_pressure_compensation.sv
// A temperature beat runs three products; a pressure beat runs thirteen and one quotient,
// or stops before the quotient with a fault when the divisor is zero.
// Each product goes through the shared two-bit-per-cycle multiplier, the quotient through the divider.
// Throughput: one beat at a time; the next input can be accepted in the cycle after the result
// moves into the output register, where it may still wait.
// Reset (aresetn, synchronous, active low) clears the calibration registers, the
// fine temperature and all handshake state; no clearing pass is needed.
// ----------------------------------------------------------------------------
// temp_pressure_compensation
// Integer temperature and pressure compensation of 20-bit raw readings with
// calibration words held in configuration registers.
// ----------------------------------------------------------------------------
module temp_pressure_compensation
    import tpc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  tpc_in_t              s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output tpc_out_t             m_data
);

    logic [TEMP_CALIB_W-1:0]    temp_calib_reg, temp_calib_next;
    logic [PRESS_CALIB_A_W-1:0] press_a_reg, press_a_next;
    logic [PRESS_CALIB_B_W-1:0] press_b_reg, press_b_next;
    logic [PRESS_CALIB_C_W-1:0] press_c_reg, press_c_next;
    logic                       m_valid_reg, m_valid_next;
    tpc_out_t                   m_data_reg, m_data_next;
    tpc_calib_t                 calib;
    logic                       res_valid, res_ready;
    tpc_out_t                   res_data;

    // Configuration writes; indexes past the last register are dropped.
    always_comb begin
        temp_calib_next = temp_calib_reg;
        press_a_next    = press_a_reg;
        press_b_next    = press_b_reg;
        press_c_next    = press_c_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_TEMP_CALIB:    temp_calib_next = cfg_data[TEMP_CALIB_W-1:0];
                REG_PRESS_CALIB_A: press_a_next    = cfg_data[PRESS_CALIB_A_W-1:0];
                REG_PRESS_CALIB_B: press_b_next    = cfg_data[PRESS_CALIB_B_W-1:0];
                REG_PRESS_CALIB_C: press_c_next    = cfg_data[PRESS_CALIB_C_W-1:0];
                default: ;
            endcase
        end
    end

    // Output register: refilled when empty or when its beat is taken.
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_data_next  = res_data;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_calib_reg <= '0;
            press_a_reg    <= '0;
            press_b_reg    <= '0;
            press_c_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            temp_calib_reg <= temp_calib_next;
            press_a_reg    <= press_a_next;
            press_b_reg    <= press_b_next;
            press_c_reg    <= press_c_next;
            m_valid_reg    <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    // Calibration field unpacking.
    assign calib.t1  = temp_calib_reg[15:0];
    assign calib.t2  = temp_calib_reg[31:16];
    assign calib.t3  = temp_calib_reg[39:32];
    assign calib.p1  = press_a_reg[15:0];
    assign calib.p2  = press_a_reg[31:16];
    assign calib.p3  = press_a_reg[39:32];
    assign calib.p4  = press_a_reg[55:40];
    assign calib.p5  = press_b_reg[15:0];
    assign calib.p6  = press_b_reg[23:16];
    assign calib.p7  = press_b_reg[31:24];
    assign calib.p8  = press_b_reg[47:32];
    assign calib.p9  = press_c_reg[15:0];
    assign calib.p10 = press_c_reg[23:16];

    tpc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .calib     (calib),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for temp_pressure_compensation. A bit-exact integer
// predictor computes each expected result when its input beat is accepted.
// Calibration registers are rewritten between blocks of beats, under several
// sender and receiver idle patterns.
// ----------------------------------------------------------------------------
module tb;
    import tpc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    tpc_in_t              s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    tpc_out_t             m_data;

    temp_pressure_compensation dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // Predictor copy of the registers and the fine temperature.
    logic [63:0] cal_temp = '0;
    logic [63:0] cal_pa = '0;
    logic [63:0] cal_pb = '0;
    logic [63:0] cal_pc = '0;
    logic [31:0] fine_now = '0;

    tpc_in_t  readings_q[$];
    tpc_out_t expected_q[$];
    int       tx_idle = 0;
    int       rx_idle = 0;
    int       mismatches = 0;
    bit       failed = 1'b0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Temperature compensation; updates the kept fine temperature.
    function automatic longint compensate_temp(longint adc);
        longint t1, t2, t3, a, b, h, c;
        t1 = longint'({48'd0, cal_temp[15:0]});
        t2 = $signed(cal_temp[31:16]);
        t3 = $signed(cal_temp[39:32]);
        a = (adc >>> 3) - t1 * 2;
        b = (a * t2) >>> 11;
        h = a >>> 1;
        c = (h * h) >>> 12;
        c = (c * (t3 * 16)) >>> 14;
        fine_now = 32'(b + c);
        return (longint'($signed(fine_now)) * 5 + 128) >>> 8;
    endfunction

    // Pressure compensation from the kept fine temperature.
    function automatic longint compensate_press(longint adc, output bit fault);
        longint p1, p2, p3, p4, p5, p6, p7, p8, p9;
        longint a, q, sq, b, v1, v2, v3;
        logic [63:0] pr, dv, sq2, cu, cube, p10;
        p1 = longint'({48'd0, cal_pa[15:0]});
        p2 = $signed(cal_pa[31:16]);
        p3 = $signed(cal_pa[39:32]);
        p4 = $signed(cal_pa[55:40]);
        p5 = $signed(cal_pb[15:0]);
        p6 = $signed(cal_pb[23:16]);
        p7 = $signed(cal_pb[31:24]);
        p8 = $signed(cal_pb[47:32]);
        p9 = $signed(cal_pc[15:0]);
        p10 = {56'd0, cal_pc[23:16]};
        a = (longint'($signed(fine_now)) >>> 1) - FINE_OFFSET;
        q = a >>> 2;
        sq = q * q;
        b = ((sq >>> 11) * p6) >>> 2;
        b = b + a * p5 * 2;
        b = (b >>> 2) + p4 * 65536;
        a = (((sq >>> 13) * (p3 * 32)) >>> 3) + ((p2 * a) >>> 1);
        a = a >>> 18;
        a = ((UNITY_Q15 + a) * p1) >>> 15;
        pr = 64'((PRESS_OFFSET - adc - (b >>> 12)) * PRESS_SCALE) & 64'hFFFF_FFFF;
        dv = 64'(a) & 64'hFFFF_FFFF;
        fault = (dv == 0);
        if (fault) begin
            return 0;
        end
        // Large readings divide first to stay inside 32 bits.
        if (pr >= 64'h4000_0000) begin
            pr = ((pr / dv) << 1) & 64'hFFFF_FFFF;
        end else begin
            pr = (pr << 1) / dv;
        end
        sq2 = ((pr >> 3) * (pr >> 3)) >> 13;
        v1 = (p9 * $signed(sq2)) >>> 12;
        v2 = (longint'(pr >> 2) * p8) >>> 13;
        cu = pr >> 8;
        cube = cu * cu * cu * p10;
        v3 = longint'(cube >> 17);
        return longint'(pr) + ((v1 + v2 + v3 + p7 * 128) >>> 4);
    endfunction

    function automatic tpc_out_t predict_reading(tpc_in_t rd);
        tpc_out_t res;
        longint   adc;
        bit       fault;
        adc = longint'({44'd0, rd.raw_reading & ADC_KEEP});
        fault = 1'b0;
        res.kind = rd.op;
        if (rd.op == OP_TEMP) begin
            res.value = 32'(compensate_temp(adc));
        end else begin
            res.value = 32'(compensate_press(adc, fault));
        end
        res.div_fault = fault;
        return res;
    endfunction

    // Input driver: holds each beat until accepted, predicts on acceptance.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                expected_q.push_back(predict_reading(s_data));
            end
            if (readings_q.size() > 0 && $urandom_range(99) >= tx_idle) begin
                s_valid <= 1'b1;
                s_data  <= readings_q.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result monitor and receiver stalls.
    always @(posedge aclk) begin
        tpc_out_t exp_beat;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle);
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    failed = 1'b1;
                    $display("ERROR: unexpected result beat %p", m_data);
                end else begin
                    exp_beat = expected_q.pop_front();
                    if (m_data.kind !== exp_beat.kind || m_data.value !== exp_beat.value
                        || m_data.div_fault !== exp_beat.div_fault) begin
                        failed = 1'b1;
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("ERROR: expected %p, got %p", exp_beat, m_data);
                        end
                    end
                end
            end
        end
    end

    // Waits until every queued beat has been sent and answered, then drains.
    task automatic wait_quiet();
        while (readings_q.size() > 0 || s_valid || expected_q.size() > 0) begin
            @(posedge aclk);
        end
        repeat (600) @(posedge aclk);
    endtask

    // One register write; the channel idles before the next one.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_TEMP_CALIB:    cal_temp = val & ((64'd1 << TEMP_CALIB_W) - 1);
            REG_PRESS_CALIB_A: cal_pa   = val & ((64'd1 << PRESS_CALIB_A_W) - 1);
            REG_PRESS_CALIB_B: cal_pb   = val & ((64'd1 << PRESS_CALIB_B_W) - 1);
            REG_PRESS_CALIB_C: cal_pc   = val & ((64'd1 << PRESS_CALIB_C_W) - 1);
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Plausible sensor calibration with small random spread.
    task automatic load_typical();
        write_reg(REG_TEMP_CALIB, {24'd0, 8'(3 + $urandom_range(4)),
                  16'(26000 + $urandom_range(1000)), 16'(26000 + $urandom_range(1000))});
        write_reg(REG_PRESS_CALIB_A, {8'd0, 16'(2000 + $urandom_range(3000)),
                  8'(88), 16'(-10000 - int'($urandom_range(500))),
                  16'(36000 + $urandom_range(2000))});
        write_reg(REG_PRESS_CALIB_B, {16'd0, 16'(-300 + int'($urandom_range(100))),
                  8'(30), 8'(30), 16'(-100 + int'($urandom_range(50)))});
        write_reg(REG_PRESS_CALIB_C, {40'd0, 8'(30), 16'(-2000 + int'($urandom_range(400)))});
    endtask

    task automatic load_all(logic [63:0] val);
        write_reg(REG_TEMP_CALIB, val);
        write_reg(REG_PRESS_CALIB_A, val);
        write_reg(REG_PRESS_CALIB_B, val);
        write_reg(REG_PRESS_CALIB_C, val);
    endtask

    function automatic tpc_in_t random_reading();
        tpc_in_t rd;
        rd.op = 1'($urandom_range(1));
        case ($urandom_range(5))
            0:       rd.raw_reading = RAW_W'($urandom);
            1:       rd.raw_reading = $urandom_range(1) ? '1 : '0;
            2, 3:    rd.raw_reading = RAW_W'(380000 + $urandom_range(200000));
            default: rd.raw_reading = RAW_W'(250000 + $urandom_range(300000));
        endcase
        return rd;
    endfunction

    // Stimulus sequence.
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset calibration: pressure with a zero divisor, temperature from zeros.
        readings_q.push_back('{OP_PRESS, 20'd0});
        readings_q.push_back('{OP_TEMP, 20'hFFFFF});
        readings_q.push_back('{OP_PRESS, 20'hFFFFF});
        readings_q.push_back('{OP_TEMP, 20'd0});
        wait_quiet();

        // Out-of-range indexes are ignored.
        write_reg(CFG_IDX_W'(4), '1);
        write_reg('1, '1);
        load_typical();
        // Pressure before any temperature in this block uses a zero fine temperature.
        for (int i = 0; i < 4; i++) begin
            readings_q.push_back('{OP_PRESS, RAW_W'(415148) ^ RAW_W'(i)});
        end
        readings_q.push_back('{OP_TEMP, 20'd0});
        readings_q.push_back('{OP_TEMP, 20'hFFFFF});
        readings_q.push_back('{OP_TEMP, 20'd519888});
        readings_q.push_back('{OP_PRESS, 20'd0});
        readings_q.push_back('{OP_PRESS, 20'hFFFFF});
        readings_q.push_back('{OP_PRESS, 20'd415148});
        readings_q.push_back('{OP_TEMP, 20'h80000});
        readings_q.push_back('{OP_PRESS, 20'h7FFFF});
        wait_quiet();

        // Extremes: every register all ones.
        load_all('1);
        for (int i = 0; i < 6; i++) begin
            readings_q.push_back('{1'(i), i[1] ? 20'hFFFFF : 20'd0});
        end
        wait_quiet();

        // Random blocks under three idle patterns, with new settings each block.
        for (int blk = 0; blk < 9; blk++) begin
            tx_idle = (blk < 3) ? 6 : (blk < 6) ? 58 : 0;
            rx_idle = (blk < 3) ? 58 : (blk < 6) ? 6 : 0;
            case (blk % 3)
                0: load_typical();
                1: begin
                    write_reg(REG_TEMP_CALIB, {$urandom, $urandom});
                    write_reg(REG_PRESS_CALIB_A, {$urandom, $urandom});
                    write_reg(REG_PRESS_CALIB_B, {$urandom, $urandom});
                    write_reg(REG_PRESS_CALIB_C, {$urandom, $urandom});
                end
                default: begin
                    load_typical();
                    write_reg(REG_PRESS_CALIB_A, blk[1] ? 64'h0 : {$urandom, $urandom});
                end
            endcase
            for (int n = 0; n < 50; n++) begin
                readings_q.push_back(random_reading());
            end
            wait_quiet();
        end

        if (failed || expected_q.size() != 0) begin
            $display("*** FAILED ***");
        end else begin
            $display("*** PASSED ***");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #25ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
